// ----- hdl/delta_timer_queue_unit_assert.svh -----
// Assertion macros for the timer queue RTL.
`ifndef DELTA_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_TIMER_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// Next-cycle implication, checked outside reset.
`define DTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ----- hdl/dtq_pkg.sv -----
package dtq_pkg;

  localparam int unsigned Depth = 16;

  typedef enum logic [1:0] {
    MODE_SCHED = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_POP   = 2'd2
  } dtq_mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  item_id;
    logic [15:0] delay;
    logic [15:0] elapsed;
  } dtq_in_t;

  typedef struct packed {
    logic       popped_valid;
    logic [7:0] popped_id;
    logic       dropped;
  } dtq_out_t;

  // One queue slot as it moves between neighboring cells.
  typedef struct packed {
    logic        valid;
    logic [7:0]  id;
    logic [15:0] delay;
  } dtq_entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic        sched;
    logic        shift;
    logic        pop;
    logic [7:0]  id;
    logic [15:0] delay;
    logic [15:0] elapsed;
  } dtq_cmd_t;

endpackage

// ----- hdl/dtq_cell.sv -----
module dtq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtq_pkg::dtq_cmd_t   cmd_i,
  input  dtq_pkg::dtq_entry_t left_i,
  input  logic              left_after_i,
  input  dtq_pkg::dtq_entry_t right_i,
  output dtq_pkg::dtq_entry_t entry_o,
  output logic              after_o
);

  logic        valid_q, valid_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] delay_q, delay_d;

  // This slot stays ahead of a new entry when it expires no later
  assign after_o = valid_q && (delay_q <= cmd_i.delay);

  assign entry_o.valid = valid_q;
  assign entry_o.id    = id_q;
  assign entry_o.delay = delay_q;

  // Pick the next slot contents
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    delay_d = delay_q;
    if (cmd_i.sched) begin
      if (!after_o) begin
        valid_d = valid_q | left_i.valid;
        if (left_after_i) begin
          id_d    = cmd_i.id;
          delay_d = cmd_i.delay;
        end else begin
          id_d    = left_i.id;
          delay_d = left_i.delay;
        end
      end
    end else if (cmd_i.shift) begin
      if (delay_q <= cmd_i.elapsed) begin
        delay_d = '0;
      end else begin
        delay_d = delay_q - cmd_i.elapsed;
      end
    end else if (cmd_i.pop) begin
      valid_d = right_i.valid;
      id_d    = right_i.id;
      delay_d = right_i.delay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    delay_q <= delay_d;
  end

endmodule

// ----- hdl/delta_timer_queue_unit.sv -----
// Timer queue of dtq_pkg::Depth entries, each an 8-bit id with a 16-bit delay.
// Input channel: in_valid_i / in_stall_o carry one transaction of mode,
//   item_id, delay and elapsed. Mode schedule inserts an entry behind all
//   entries with equal or smaller delay; mode shift subtracts elapsed time
//   from every entry, saturating at zero; mode pop removes the head if its
//   delay is zero. Any other mode does nothing.
// Output channel: out_valid_o / out_stall_i carry exactly one result per
//   input transaction: popped_valid, popped_id and dropped (queue full).
// The result is registered and valid in the cycle after input accept. Throughput
//   is one transaction per cycle while the result is not stalled: every cell of
//   the chain updates in parallel from its own compare and its two neighbors.
// The result register is the only buffer; while it holds a stalled result,
//   in_stall_o is high and the queue does not change.
// Reset empties the queue (all cell valid bits clear) and drops any pending
//   result. The block is ready in the first cycle after reset.
`include "delta_timer_queue_unit_assert.svh"

module delta_timer_queue_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dtq_pkg::dtq_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dtq_pkg::dtq_out_t out_data_o
);

  localparam int unsigned N = dtq_pkg::Depth;

  dtq_pkg::dtq_entry_t entries [N];
  logic [N-1:0]        after;
  logic [N-1:0]        valid_vec;
  dtq_pkg::dtq_cmd_t   cmd;
  dtq_pkg::dtq_entry_t new_entry;
  dtq_pkg::dtq_entry_t empty_entry;

  logic              in_acc;
  logic              full;
  logic              head_exp;
  logic              out_valid_q, out_valid_d;
  dtq_pkg::dtq_out_t out_q, out_d;

  // Accept while the result register is free or being drained
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign full     = entries[N-1].valid;
  assign head_exp = entries[0].valid && (entries[0].delay == '0);

  // Decode the transaction into the broadcast command
  always_comb begin
    cmd         = '0;
    cmd.id      = in_data_i.item_id;
    cmd.delay   = in_data_i.delay;
    cmd.elapsed = in_data_i.elapsed;
    if (in_acc) begin
      unique case (dtq_pkg::dtq_mode_e'(in_data_i.mode))
        dtq_pkg::MODE_SCHED: cmd.sched = ~full;
        dtq_pkg::MODE_SHIFT: cmd.shift = 1'b1;
        dtq_pkg::MODE_POP:   cmd.pop   = head_exp;
        default:             cmd       = cmd;
      endcase
    end
  end

  assign new_entry.valid   = 1'b1;
  assign new_entry.id      = in_data_i.item_id;
  assign new_entry.delay   = in_data_i.delay;
  assign empty_entry       = '0;

  // Build the chain of cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    dtq_pkg::dtq_entry_t left_e, right_e;
    logic                left_a;
    if (k == 0) begin : g_first
      assign left_e = new_entry;
      assign left_a = 1'b1;
    end else begin : g_mid
      assign left_e = entries[k-1];
      assign left_a = after[k-1];
    end
    if (k == N-1) begin : g_last
      assign right_e = empty_entry;
    end else begin : g_inner
      assign right_e = entries[k+1];
    end

    dtq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_e),
      .left_after_i (left_a),
      .right_i      (right_e),
      .entry_o      (entries[k]),
      .after_o      (after[k])
    );
    assign valid_vec[k] = entries[k].valid;
  end

  // Form the result of the accepted transaction
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      unique case (dtq_pkg::dtq_mode_e'(in_data_i.mode))
        dtq_pkg::MODE_SCHED: out_d.dropped = full;
        dtq_pkg::MODE_POP: begin
          out_d.popped_valid = head_exp;
          out_d.popped_id    = head_exp ? entries[0].id : 8'd0;
        end
        default: out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupied cells always form an unbroken run from the head
  `DTQ_ASSERT_NOW(a_fill_contiguous, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // A schedule into a full queue reports a drop
  `DTQ_ASSERT_NEXT(a_drop_on_full,
      in_acc && (in_data_i.mode == dtq_pkg::MODE_SCHED) && full,
      out_valid_q && out_q.dropped)
  // An expired-head pop removes exactly one entry and reports it
  `DTQ_ASSERT_NEXT(a_pop_shrinks,
      in_acc && (in_data_i.mode == dtq_pkg::MODE_POP) && head_exp,
      out_q.popped_valid && ($countones(valid_vec) + 1 == $past($countones(valid_vec))))

endmodule
